FILE: rtl/core/sssa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sssa_pkg
// shared types, codes and saturating arithmetic for the sparse stiffness
// scatter-add block
// ----------------------------------------------------------------------------
package sssa_pkg;

	localparam int NODE_COUNT_DEF    = 1024;
	localparam int SLOTS_PER_ROW_DEF = 8;

	localparam int COL_W  = 10;
	localparam int VAL_W  = 32;
	localparam int SLOT_W = 3;

	localparam logic OP_ACC  = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef struct packed {
		logic             valid;
		logic [COL_W-1:0] col;
	} tag_t;

	function automatic logic signed [VAL_W-1:0] sat_add(
		input logic signed [VAL_W-1:0] a,
		input logic signed [VAL_W-1:0] b
	);
		logic signed [VAL_W:0] s;
		s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
		if (s[VAL_W] != s[VAL_W-1]) begin
			sat_add = s[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
		end else begin
			sat_add = s[VAL_W-1:0];
		end
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/sparse_stiffness_scatter_add.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_stiffness_scatter_add
// scatter-add of local stiffness rows into a row-slotted sparse matrix
//
// Input channel (in_valid / in_ready) takes one item: an accumulate of one
// local row (three columns, three values, one load term) or a read of one
// slot of a row. Output channel (out_valid / out_ready) gives one result
// item per input item, in order.
// The tag rows and row loads live in registered-read memories, and the
// slot sums in a third. An accumulate's result is registered after row
// read, one slot search and sum read-modify-write per column through a
// single sum read port, then write-back of the tag row and load. A read's
// result is registered after the row and slot read and the write-back step.
// One item is in flight at a time; the next is taken once the result sits
// in the output register.
// After reset the block runs a clearing pass over the tag rows and loads
// with in_ready low. When the receiver stalls, the result waits in the
// output register and the block holds its finished item in the write-back
// step until the register frees.
// ----------------------------------------------------------------------------
module sparse_stiffness_scatter_add #(
	parameter int NODE_COUNT    = sssa_pkg::NODE_COUNT_DEF,
	parameter int SLOTS_PER_ROW = sssa_pkg::SLOTS_PER_ROW_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,

	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                opcode,
	input  wire logic [sssa_pkg::COL_W-1:0]          row_node,
	input  wire logic [sssa_pkg::COL_W-1:0]          col_node_a,
	input  wire logic [sssa_pkg::COL_W-1:0]          col_node_b,
	input  wire logic [sssa_pkg::COL_W-1:0]          col_node_c,
	input  wire logic signed [sssa_pkg::VAL_W-1:0]   stiff_a,
	input  wire logic signed [sssa_pkg::VAL_W-1:0]   stiff_b,
	input  wire logic signed [sssa_pkg::VAL_W-1:0]   stiff_c,
	input  wire logic signed [sssa_pkg::VAL_W-1:0]   load_add,
	input  wire logic [sssa_pkg::SLOT_W-1:0]         read_slot,

	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic                                     status,
	output logic                                     slot_used,
	output logic [sssa_pkg::COL_W-1:0]               slot_column,
	output logic signed [sssa_pkg::VAL_W-1:0]        slot_value,
	output logic signed [sssa_pkg::VAL_W-1:0]        row_load
);

	localparam int ROW_W  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int SW     = $clog2(SLOTS_PER_ROW);
	localparam int DEPTH  = NODE_COUNT * SLOTS_PER_ROW;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int COL_W  = sssa_pkg::COL_W;
	localparam int VAL_W  = sssa_pkg::VAL_W;

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_LOOK = 3'd2;
	localparam logic [2:0] ST_COL  = 3'd3;
	localparam logic [2:0] ST_WB   = 3'd4;

	// memories
	sssa_pkg::tag_t [SLOTS_PER_ROW-1:0] tag_mem [NODE_COUNT];
	logic signed [VAL_W-1:0]            load_mem [NODE_COUNT];
	logic signed [VAL_W-1:0]            sum_mem [DEPTH];

	sssa_pkg::tag_t [SLOTS_PER_ROW-1:0] tag_rd_q;
	logic signed [VAL_W-1:0]            load_rd_q;
	logic signed [VAL_W-1:0]            sum_rd_q;

	// control
	logic [2:0]       st_q;
	logic [ROW_W-1:0] clr_cnt_q;
	logic [1:0]       cidx_q;
	logic             ovf_q;

	// item registers
	logic                    op_q;
	logic                    row_ok_q;
	logic                    slot_ok_q;
	logic [ROW_W-1:0]        row_idx_q;
	logic [ADDR_W-1:0]       base_q;
	logic [SW-1:0]           rslot_q;
	logic [COL_W-1:0]        cols_q [3];
	logic signed [VAL_W-1:0] stiffs_q [3];
	logic signed [VAL_W-1:0] load_add_q;

	// working row
	sssa_pkg::tag_t [SLOTS_PER_ROW-1:0] tags_q;
	logic signed [VAL_W-1:0]            load_q;

	// sum read-modify-write stage
	logic                    wr_v_s1;
	logic                    new_s1;
	logic [ADDR_W-1:0]       addr_s1;
	logic signed [VAL_W-1:0] val_s1;
	logic                    wr_v_q;
	logic [ADDR_W-1:0]       wr_addr_q;
	logic signed [VAL_W-1:0] wr_data_q;

	// output register
	logic                    out_valid_q;
	logic                    status_q;
	logic                    used_q;
	logic [COL_W-1:0]        column_q;
	logic signed [VAL_W-1:0] value_q;
	logic signed [VAL_W-1:0] rload_q;

	// accept-side decode
	logic              accept;
	logic              in_row_ok;
	logic              in_slot_ok;
	logic [ROW_W-1:0]  in_row_idx;
	logic [SW-1:0]     in_slot_idx;
	logic [ADDR_W-1:0] in_base;

	// column search
	logic [COL_W-1:0]        cur_col;
	logic [SW-1:0]           sel;
	logic                    hit;
	logic                    claim;
	logic [ADDR_W-1:0]       col_addr;

	// memory ports
	logic                               sum_re;
	logic [ADDR_W-1:0]                  sum_ra;
	logic signed [VAL_W-1:0]            sum_old;
	logic signed [VAL_W-1:0]            sum_wd;
	logic                               row_we;
	logic [ROW_W-1:0]                   row_wa;
	sssa_pkg::tag_t [SLOTS_PER_ROW-1:0] tag_wd;
	logic signed [VAL_W-1:0]            load_wd;
	logic                               wb_go;
	sssa_pkg::tag_t                     rtag;

	assign in_ready  = (st_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	assign in_row_ok   = (32'(row_node) < 32'(NODE_COUNT));
	assign in_slot_ok  = (32'(read_slot) < 32'(SLOTS_PER_ROW));
	assign in_row_idx  = in_row_ok ? ROW_W'(row_node) : '0;
	assign in_slot_idx = in_slot_ok ? SW'(read_slot) : '0;
	assign in_base     = ADDR_W'(32'(in_row_idx) * SLOTS_PER_ROW);

	// first slot that matches the column or is still empty
	assign cur_col = cols_q[cidx_q];
	always_comb begin
		sel = '0;
		hit = 1'b0;
		for (int i = SLOTS_PER_ROW - 1; i >= 0; i--) begin
			if (!tags_q[i].valid || tags_q[i].col == cur_col) begin
				sel = SW'(i);
				hit = 1'b1;
			end
		end
	end
	assign claim    = hit && !tags_q[sel].valid;
	assign col_addr = base_q + ADDR_W'(sel);

	assign sum_re = accept || (st_q == ST_COL);
	assign sum_ra = (st_q == ST_COL) ? col_addr : (in_base + ADDR_W'(in_slot_idx));

	// freshly claimed slot starts from zero, back-to-back hit takes the last write
	always_comb begin
		if (new_s1) begin
			sum_old = '0;
		end else if (wr_v_q && wr_addr_q == addr_s1) begin
			sum_old = wr_data_q;
		end else begin
			sum_old = sum_rd_q;
		end
	end
	assign sum_wd = sssa_pkg::sat_add(sum_old, val_s1);

	assign wb_go = !out_valid_q || out_ready;

	always_comb begin
		row_we  = 1'b0;
		row_wa  = row_idx_q;
		tag_wd  = tags_q;
		load_wd = load_q;
		if (st_q == ST_CLR) begin
			row_we  = 1'b1;
			row_wa  = clr_cnt_q;
			tag_wd  = '0;
			load_wd = '0;
		end else if (st_q == ST_WB && op_q == sssa_pkg::OP_ACC && row_ok_q) begin
			row_we = 1'b1;
		end
	end

	assign rtag = tag_rd_q[rslot_q];

	always_ff @(posedge clk) begin
		if (row_we) begin
			tag_mem[row_wa]  <= tag_wd;
			load_mem[row_wa] <= load_wd;
		end
		if (accept) begin
			tag_rd_q  <= tag_mem[in_row_idx];
			load_rd_q <= load_mem[in_row_idx];
		end
		if (wr_v_s1) begin
			sum_mem[addr_s1] <= sum_wd;
		end
		if (sum_re) begin
			sum_rd_q <= sum_mem[sum_ra];
		end
	end

	// item and datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q        <= opcode;
			row_ok_q    <= in_row_ok;
			slot_ok_q   <= in_slot_ok;
			row_idx_q   <= in_row_idx;
			base_q      <= in_base;
			rslot_q     <= in_slot_idx;
			cols_q[0]   <= col_node_a;
			cols_q[1]   <= col_node_b;
			cols_q[2]   <= col_node_c;
			stiffs_q[0] <= stiff_a;
			stiffs_q[1] <= stiff_b;
			stiffs_q[2] <= stiff_c;
			load_add_q  <= load_add;
		end
		if (st_q == ST_LOOK) begin
			tags_q <= tag_rd_q;
			load_q <= (op_q == sssa_pkg::OP_ACC) ? sssa_pkg::sat_add(load_rd_q, load_add_q)
				: load_rd_q;
		end else if (st_q == ST_COL && claim) begin
			tags_q[sel] <= '{valid: 1'b1, col: cur_col};
		end
		new_s1    <= claim;
		addr_s1   <= col_addr;
		val_s1    <= stiffs_q[cidx_q];
		wr_addr_q <= addr_s1;
		wr_data_q <= sum_wd;
		if (st_q == ST_WB && wb_go) begin
			status_q <= (op_q == sssa_pkg::OP_ACC) && row_ok_q && ovf_q;
			used_q   <= (op_q == sssa_pkg::OP_READ) && row_ok_q && slot_ok_q && rtag.valid;
			column_q <= ((op_q == sssa_pkg::OP_READ) && row_ok_q && slot_ok_q && rtag.valid)
				? rtag.col : '0;
			value_q  <= ((op_q == sssa_pkg::OP_READ) && row_ok_q && slot_ok_q && rtag.valid)
				? sum_rd_q : '0;
			rload_q  <= row_ok_q ? load_q : '0;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_CLR;
			clr_cnt_q   <= '0;
			cidx_q      <= '0;
			ovf_q       <= 1'b0;
			wr_v_s1     <= 1'b0;
			wr_v_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			wr_v_s1 <= (st_q == ST_COL) && hit;
			wr_v_q  <= wr_v_s1;
			if (st_q == ST_WB && wb_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				ST_CLR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (32'(clr_cnt_q) == NODE_COUNT - 1) begin
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						ovf_q <= 1'b0;
						st_q  <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					cidx_q <= '0;
					st_q   <= (op_q == sssa_pkg::OP_ACC && row_ok_q) ? ST_COL : ST_WB;
				end
				ST_COL: begin
					if (!hit) begin
						ovf_q <= 1'b1;
					end
					if (cidx_q == 2'd2) begin
						st_q <= ST_WB;
					end else begin
						cidx_q <= cidx_q + 1'b1;
					end
				end
				ST_WB: begin
					if (wb_go) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign status      = status_q;
	assign slot_used   = used_q;
	assign slot_column = column_q;
	assign slot_value  = value_q;
	assign row_load    = rload_q;

endmodule
`default_nettype wire
